// ===== src/fmipp_pkg.sv =====
// Package for the first-match IP/port policy block: rule and transaction
// payload types, opcodes, register indexes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package fmipp_pkg;

  localparam int RULE_DEPTH_DEF = 256;
  localparam int CFG_DATA_W     = 9;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CHECK = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_ACTIVE_RULES  = 1'b0,
    CFG_DEFAULT_ALLOW = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        allow;
    logic [31:0] addr;
    logic [15:0] port;
  } rule_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  rule_index;
    logic        rule_allow;
    logic [31:0] ip_addr;
    logic [15:0] port;
  } in_item_t;

  typedef struct packed {
    logic allowed;
  } out_item_t;

endpackage

// ===== src/fmipp_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from fmipp_pkg at instantiation.
`timescale 1ns / 1ps

interface fmipp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fmipp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fmipp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fmipp_match.sv =====
// Rule comparator: one stored rule against the destination being checked.
// A zero address or port in the rule matches anything. Uses fmipp_pkg.
`timescale 1ns / 1ps

module fmipp_match
  import fmipp_pkg::*;
(
  input  rule_t       rule,
  input  logic [31:0] key_addr,
  input  logic [15:0] key_port,
  output logic        hit
);

  logic addr_ok;
  logic port_ok;

  assign addr_ok = (rule.addr == 32'd0) || (rule.addr == key_addr);
  assign port_ok = (rule.port == 16'd0) || (rule.port == key_port);
  assign hit     = addr_ok && port_ok;

endmodule

// ===== src/first_match_ip_port_policy.sv =====
// Top level of the first-match IP/port policy block: controller, rule memory
// and comparator. Depends on fmipp_pkg, fmipp_chan_if, fmipp_ram, fmipp_match.
`timescale 1ns / 1ps

// Usage
// The input channel in_ch carries one transaction per item. A write
// transaction (opcode OP_WRITE) stores a rule {rule_allow, ip_addr, port} in
// slot rule_index and produces no result; slots at or beyond RULE_DEPTH are
// ignored. A check transaction (opcode OP_CHECK) scans the rules from slot 0
// up to min(active_rules, RULE_DEPTH) - 1 and returns on out_ch the action of
// the first rule whose address and port match (zero in a rule field matches
// anything), or default_allow when none matches.
// A check reads one rule per cycle through the single read port of the rule
// memory and one comparator, then returns its result on out_ch; the input is
// not ready while the check is in progress. A check with N = 0, N being the
// effective rule count, goes straight to default_allow without a scan. The
// output register frees the controller as soon as its result is taken; if the
// receiver stalls, the finished result waits in the controller and the next
// transaction is held off until it is delivered. After reset the memory is
// cleared to zero (a deny-any rule in every slot) by a pass over every slot,
// during which in_ch is not ready. The configuration port (cfg_we, cfg_index,
// cfg_wdata) must be written by the user only while no check is in flight;
// the block itself does not enforce this.
module first_match_ip_port_policy
  import fmipp_pkg::*;
#(
  parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fmipp_chan_if.sink            in_ch,
  fmipp_chan_if.source          out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Address width of the memory, width of a count up to the depth, and a
  // width wide enough to compare slot numbers and rule counts with the depth.
  localparam int AW   = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int CNTW = $clog2(RULE_DEPTH + 1);
  localparam int WW   = ((CNTW > CFG_DATA_W) ? CNTW : CFG_DATA_W) + 1;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_ptr_r, clr_ptr_nxt;
  logic [CNTW-1:0]       ptr_r, ptr_nxt;
  logic [CNTW-1:0]       limit_r, limit_nxt;
  logic                  dv_r, dv_nxt;
  logic [31:0]           key_addr_r, key_addr_nxt;
  logic [15:0]           key_port_r, key_port_nxt;
  logic                  res_r, res_nxt;
  logic                  ov_r, ov_nxt;
  logic                  oa_r, oa_nxt;
  logic [CFG_DATA_W-1:0] active_rules_r;
  logic                  default_allow_r;

  in_item_t              item;
  logic                  in_fire;
  logic [WW-1:0]         idx_ext;
  logic                  idx_ok;
  logic [WW-1:0]         eff_count;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  rule_t                 ram_wdata;
  rule_t                 ram_rdata;
  logic                  hit;
  logic                  more;

  assign item        = in_ch.data;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = ov_r;
  assign out_ch.data.allowed = oa_r;

  // Slot range check and saturation of the rule count at the table depth.
  assign idx_ext   = WW'(item.rule_index);
  assign idx_ok    = idx_ext < WW'(RULE_DEPTH);
  assign eff_count = (WW'(active_rules_r) > WW'(RULE_DEPTH)) ? WW'(RULE_DEPTH)
                                                            : WW'(active_rules_r);

  // The write port serves the clearing pass and rule writes; the read port
  // follows the scan pointer, so data for slot ptr-1 is present while
  // slot ptr is being addressed.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = in_fire && (item.opcode == OP_WRITE) && idx_ok;
      ram_waddr = idx_ext[AW-1:0];
      ram_wdata = '{allow: item.rule_allow, addr: item.ip_addr, port: item.port};
    end
  end

  fmipp_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  fmipp_match u_match (
    .rule     (ram_rdata),
    .key_addr (key_addr_r),
    .key_port (key_port_r),
    .hit      (hit)
  );

  assign more = ptr_r < limit_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rules_r  <= '0;
      default_allow_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_RULES:  active_rules_r  <= cfg_wdata;
        CFG_DEFAULT_ALLOW: default_allow_r <= cfg_wdata[0];
        default:           active_rules_r  <= active_rules_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ptr_r <= '0;
      ptr_r     <= '0;
      limit_r   <= '0;
      dv_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      ptr_r     <= ptr_nxt;
      limit_r   <= limit_nxt;
      dv_r      <= dv_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_addr_r <= key_addr_nxt;
    key_port_r <= key_port_nxt;
    res_r      <= res_nxt;
    oa_r       <= oa_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_ptr_nxt  = clr_ptr_r;
    ptr_nxt      = ptr_r;
    limit_nxt    = limit_r;
    dv_nxt       = 1'b0;
    key_addr_nxt = key_addr_r;
    key_port_nxt = key_port_r;
    res_nxt      = res_r;
    ov_nxt       = ov_r && !out_ch.ready;
    oa_nxt       = oa_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_ptr_nxt = clr_ptr_r + AW'(1);
        if (clr_ptr_r == AW'(RULE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (item.opcode == OP_CHECK)) begin
          key_addr_nxt = item.ip_addr;
          key_port_nxt = item.port;
          limit_nxt    = eff_count[CNTW-1:0];
          ptr_nxt      = '0;
          if (eff_count == '0) begin
            res_nxt   = default_allow_r;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (more) begin
          ptr_nxt = ptr_r + CNTW'(1);
          dv_nxt  = 1'b1;
        end
        // The first hit ends the scan; past the last rule the default applies.
        if (dv_r) begin
          if (hit) begin
            res_nxt   = ram_rdata.allow;
            dv_nxt    = 1'b0;
            state_nxt = ST_DONE;
          end else if (!more) begin
            res_nxt   = default_allow_r;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oa_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The scan pointer never runs past the effective rule count.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ptr_r <= limit_r))
    else $error("scan pointer beyond rule count");

  // A new result appears only when the controller hands one over.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside hand-over");

  // Read data is only considered while a scan is running.
  a_dv_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == ST_SCAN))
    else $error("read data flagged outside scan");

  // A check with rules to scan goes into the scan, never straight to a result.
  a_check_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (item.opcode == OP_CHECK) && (eff_count != '0)) |=>
      (state_r == ST_SCAN))
    else $error("check did not start a scan");

endmodule
